>>> design/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared constants, codes and types of the multi-level priority fifo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlpf_pkg;

    // default sizing
    localparam int LEVELS_DEF     = 16;
    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    // fixed port widths
    localparam int MODE_W   = 2;
    localparam int ELEM_W   = 32;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [LEVEL_W-1:0] HIGHEST_LEVEL_RESET = 4'd15;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEVEL = 2'd3;

    typedef struct packed {
        logic elem_we;
        logic link_we;
    } pool_we_t;

    typedef struct packed {
        logic head_we;
        logic tail_we;
    } table_we_t;

endpackage

`default_nettype wire

>>> design/mlpf_pool.sv
// ----------------------------------------------------------------------------
// mlpf_pool
// Shared entry pool: element values and next links, one write and one
// registered read port per store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpf_pool
    import mlpf_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int IW        = $clog2(CAPACITY)
)
(
    input  wire logic                  clk,
    input  wire pool_we_t              we,
    input  wire logic [IW-1:0]         elem_waddr,
    input  wire logic [ELEM_WIDTH-1:0] elem_wdata,
    input  wire logic [IW-1:0]         elem_raddr,
    output      logic [ELEM_WIDTH-1:0] elem_rdata,
    input  wire logic [IW-1:0]         link_waddr,
    input  wire logic [IW-1:0]         link_wdata,
    input  wire logic [IW-1:0]         link_raddr,
    output      logic [IW-1:0]         link_rdata
);

    logic [ELEM_WIDTH-1:0] elem_mem [CAPACITY];
    logic [IW-1:0]         link_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we.elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rdata <= elem_mem[elem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end

endmodule

`default_nettype wire

>>> design/mlpf_level_table.sv
// ----------------------------------------------------------------------------
// mlpf_level_table
// Per-level head and tail pointers, one write and one registered read port
// per table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpf_level_table
    import mlpf_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IW      = $clog2(CAPACITY),
    localparam int LW      = $clog2(LEVELS)
)
(
    input  wire logic          clk,
    input  wire table_we_t     we,
    input  wire logic [LW-1:0] head_waddr,
    input  wire logic [IW-1:0] head_wdata,
    input  wire logic [LW-1:0] head_raddr,
    output      logic [IW-1:0] head_rdata,
    input  wire logic [LW-1:0] tail_waddr,
    input  wire logic [IW-1:0] tail_wdata,
    input  wire logic [LW-1:0] tail_raddr,
    output      logic [IW-1:0] tail_rdata
);

    logic [IW-1:0] head_mem [LEVELS];
    logic [IW-1:0] tail_mem [LEVELS];

    always_ff @(posedge clk)
    begin
        if (we.head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.tail_we)
        begin
            tail_mem[tail_waddr] <= tail_wdata;
        end
        tail_rdata <= tail_mem[tail_raddr];
    end

endmodule

`default_nettype wire

>>> design/mlpf_front_enc.sv
// ----------------------------------------------------------------------------
// mlpf_front_enc
// Finds the most urgent non-empty level from the occupancy bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlpf_front_enc
    import mlpf_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    localparam int LW    = $clog2(LEVELS)
)
(
    input  wire logic [LEVELS-1:0] nonempty,
    output      logic              any,
    output      logic [LW-1:0]     idx
);

    always_comb
    begin
        any = |nonempty;
        idx = '0;
        // scan downward so the lowest set level wins
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                idx = LW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/multi_level_priority_fifo_top.sv
// ----------------------------------------------------------------------------
// multi_level_priority_fifo_top
// Strict-priority queue, one linked fifo per level in a shared entry pool.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one item: mode, elem, level.
// mode 0 enqueues elem on its level, mode 1 removes the front element of the
// lowest non-empty level, any other mode only reports. Output channel
// (out_valid / out_stall) returns one item per input item: status,
// removed_elem, head_elem, head_level, count, is_empty. cfg_wr_en /
// cfg_wr_data write highest_level; the user must do this only while the
// block is idle, which the block itself does not enforce. Items are handled
// one at a time by a small sequencer sharing the single read port of each
// store: decode, then the enqueue write or the dequeue read and write, then
// the head table read -> element store read of the front. in_stall is low
// only while idle, so a new item waits until the sequencer has finished the last.
// rst_n clears the queue and occupancy state and sets highest_level to 15.
// A finished item waits in the output register while out_stall is high; the
// next item is accepted meanwhile and its processing waits at the final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_level_priority_fifo_top
    import mlpf_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_wr_en,
    input  wire logic [LEVEL_W-1:0]  cfg_wr_data,

    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [ELEM_W-1:0]   elem,
    input  wire logic [LEVEL_W-1:0]  level,

    output      logic                out_valid,
    input  wire logic                out_stall,
    output      logic [STATUS_W-1:0] status,
    output      logic [ELEM_W-1:0]   removed_elem,
    output      logic [ELEM_W-1:0]   head_elem,
    output      logic [LEVEL_W-1:0]  head_level,
    output      logic [COUNT_W-1:0]  count,
    output      logic                is_empty
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_ENQ_WR   = 3'd2;
    localparam logic [2:0] S_DEQ_RD   = 3'd3;
    localparam logic [2:0] S_DEQ_WR   = 3'd4;
    localparam logic [2:0] S_FRONT    = 3'd5;
    localparam logic [2:0] S_FRONT_RD = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [LEVELS-1:0]   nonempty_reg, nonempty_next;
    logic [IW-1:0]       free_head_reg, free_head_next;
    logic                free_valid_reg, free_valid_next;
    logic [CW-1:0]       fresh_next_reg, fresh_next_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LEVEL_W-1:0]  highest_reg;
    logic                out_valid_reg, out_valid_next;

    // per-item working registers
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [ELEM_WIDTH-1:0] elem_reg, elem_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [STATUS_W-1:0]   st_reg, st_next;
    logic [ELEM_WIDTH-1:0] removed_reg, removed_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [LW-1:0]         fl_reg, fl_next;
    logic                  from_free_reg, from_free_next;

    // output register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ELEM_W-1:0]   removed_out_reg, removed_out_next;
    logic [ELEM_W-1:0]   head_elem_reg, head_elem_next;
    logic [LEVEL_W-1:0]  head_level_reg, head_level_next;
    logic [COUNT_W-1:0]  count_out_reg, count_out_next;
    logic                is_empty_reg, is_empty_next;

    // store ports
    pool_we_t              pool_we;
    table_we_t             table_we;
    logic [ELEM_WIDTH-1:0] elem_rdata;
    logic [IW-1:0]         link_waddr, link_wdata, link_raddr, link_rdata;
    logic [LW-1:0]         head_waddr, tail_raddr;
    logic [IW-1:0]         head_wdata, head_rdata, tail_rdata;

    logic                  enc_any;
    logic [LW-1:0]         enc_idx;
    logic [LW-1:0]         level_lw;
    logic                  level_bad;

    assign level_lw  = LW'(level_reg);
    assign level_bad = (level_reg > highest_reg) || (32'(level_reg) >= 32'(LEVELS));

    assign tail_raddr = (mode_reg == MODE_ENQ) ? level_lw : enc_idx;
    assign link_raddr = (state_reg == S_DEQ_RD) ? head_rdata : free_head_reg;

    mlpf_front_enc #(
        .LEVELS (LEVELS)
    ) u_front_enc (
        .nonempty (nonempty_reg),
        .any      (enc_any),
        .idx      (enc_idx)
    );

    mlpf_pool #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_pool (
        .clk        (clk),
        .we         (pool_we),
        .elem_waddr (slot_reg),
        .elem_wdata (elem_reg),
        .elem_raddr (head_rdata),
        .elem_rdata (elem_rdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata)
    );

    mlpf_level_table #(
        .LEVELS   (LEVELS),
        .CAPACITY (CAPACITY)
    ) u_level_table (
        .clk        (clk),
        .we         (table_we),
        .head_waddr (head_waddr),
        .head_wdata (head_wdata),
        .head_raddr (enc_idx),
        .head_rdata (head_rdata),
        .tail_waddr (level_lw),
        .tail_wdata (slot_reg),
        .tail_raddr (tail_raddr),
        .tail_rdata (tail_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        nonempty_next    = nonempty_reg;
        free_head_next   = free_head_reg;
        free_valid_next  = free_valid_reg;
        fresh_next_next  = fresh_next_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        elem_next        = elem_reg;
        level_next       = level_reg;
        st_next          = st_reg;
        removed_next     = removed_reg;
        slot_next        = slot_reg;
        fl_next          = fl_reg;
        from_free_next   = from_free_reg;
        status_next      = status_reg;
        removed_out_next = removed_out_reg;
        head_elem_next   = head_elem_reg;
        head_level_next  = head_level_reg;
        count_out_next   = count_out_reg;
        is_empty_next    = is_empty_reg;
        pool_we          = '0;
        table_we         = '0;
        link_waddr       = slot_reg;
        link_wdata       = '0;
        head_waddr       = level_lw;
        head_wdata       = slot_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    elem_next  = ELEM_WIDTH'(elem);
                    level_next = level;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_next      = STATUS_OK;
                removed_next = '0;
                state_next   = S_FRONT;
                if (mode_reg == MODE_ENQ)
                begin
                    if (level_bad)
                    begin
                        st_next = STATUS_BAD_LEVEL;
                    end
                    else if (count_reg >= CW'(CAPACITY))
                    begin
                        st_next = STATUS_FULL;
                    end
                    else
                    begin
                        slot_next      = free_valid_reg ? free_head_reg : IW'(fresh_next_reg);
                        from_free_next = free_valid_reg;
                        state_next     = S_ENQ_WR;
                    end
                end
                else if (mode_reg == MODE_DEQ)
                begin
                    if (!enc_any)
                    begin
                        st_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        fl_next    = enc_idx;
                        state_next = S_DEQ_RD;
                    end
                end
            end
            S_ENQ_WR:
            begin
                pool_we.elem_we  = 1'b1;
                table_we.tail_we = 1'b1;
                if (nonempty_reg[level_lw])
                begin
                    // chain behind the current tail
                    pool_we.link_we = 1'b1;
                    link_waddr      = tail_rdata;
                    link_wdata      = slot_reg;
                end
                else
                begin
                    table_we.head_we        = 1'b1;
                    nonempty_next[level_lw] = 1'b1;
                end
                if (from_free_reg)
                begin
                    free_head_next  = link_rdata;
                    free_valid_next = fresh_next_reg > (count_reg + CW'(1));
                end
                else
                begin
                    fresh_next_next = fresh_next_reg + CW'(1);
                end
                count_next = count_reg + CW'(1);
                state_next = S_FRONT;
            end
            S_DEQ_RD:
            begin
                slot_next  = head_rdata;
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR:
            begin
                removed_next = elem_rdata;
                if (slot_reg == tail_rdata)
                begin
                    nonempty_next[fl_reg] = 1'b0;
                end
                else
                begin
                    table_we.head_we = 1'b1;
                    head_waddr       = fl_reg;
                    head_wdata       = link_rdata;
                end
                // push the freed entry on the free list
                pool_we.link_we = 1'b1;
                link_waddr      = slot_reg;
                link_wdata      = free_valid_reg ? free_head_reg : '0;
                free_head_next  = slot_reg;
                free_valid_next = 1'b1;
                count_next      = count_reg - CW'(1);
                state_next      = S_FRONT;
            end
            S_FRONT:
            begin
                state_next = S_FRONT_RD;
            end
            S_FRONT_RD:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    status_next      = st_reg;
                    removed_out_next = ELEM_W'(removed_reg);
                    head_elem_next   = enc_any ? ELEM_W'(elem_rdata) : '0;
                    head_level_next  = enc_any ? LEVEL_W'(enc_idx) : '0;
                    count_out_next   = COUNT_W'(count_reg);
                    is_empty_next    = (count_reg == '0);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_valid_reg <= 1'b0;
            fresh_next_reg <= '0;
            count_reg      <= '0;
            highest_reg    <= HIGHEST_LEVEL_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_valid_reg <= free_valid_next;
            fresh_next_reg <= fresh_next_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                highest_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        elem_reg        <= elem_next;
        level_reg       <= level_next;
        st_reg          <= st_next;
        removed_reg     <= removed_next;
        slot_reg        <= slot_next;
        fl_reg          <= fl_next;
        from_free_reg   <= from_free_next;
        status_reg      <= status_next;
        removed_out_reg <= removed_out_next;
        head_elem_reg   <= head_elem_next;
        head_level_reg  <= head_level_next;
        count_out_reg   <= count_out_next;
        is_empty_reg    <= is_empty_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign removed_elem = removed_out_reg;
    assign head_elem    = head_elem_reg;
    assign head_level   = head_level_reg;
    assign count        = count_out_reg;
    assign is_empty     = is_empty_reg;

    // occupancy bits and element count agree on emptiness
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (nonempty_reg == '0))
        else $error("occupancy bits disagree with element count");

    // free list is non-empty exactly when a handed-out entry is not in use
    a_free_list: assert property (@(posedge clk) disable iff (!rst_n)
        free_valid_reg == (fresh_next_reg > count_reg))
        else $error("free list flag inconsistent with counters");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(CAPACITY)) && (fresh_next_reg <= CW'(CAPACITY)))
        else $error("entry counters exceed capacity");

    // an accepted item starts decoding on the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

endmodule

`default_nettype wire

>>> verif/mlpf_checker.sv
// ----------------------------------------------------------------------------
// mlpf_checker
// Watches both channels of the priority fifo, keeps a queue-based picture of
// the stored elements, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpf_checker
    import mlpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [LEVEL_W-1:0]  cfg_wr_data,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [ELEM_W-1:0]   elem,
    input  logic [LEVEL_W-1:0]  level,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [ELEM_W-1:0]   removed_elem,
    input  logic [ELEM_W-1:0]   head_elem,
    input  logic [LEVEL_W-1:0]  head_level,
    input  logic [COUNT_W-1:0]  count,
    input  logic                is_empty,

    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   removed;
        logic [ELEM_W-1:0]   head;
        logic [LEVEL_W-1:0]  head_lvl;
        logic [COUNT_W-1:0]  cnt;
        logic                empty;
    } queue_view_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] lvl;
        logic [ELEM_W-1:0]  value;
    } stored_entry_t;

    // stored elements in arrival order, each tagged with its level
    stored_entry_t      stored_q[$];
    queue_view_t        expected_q[$];
    logic [LEVEL_W-1:0] highest_allowed;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mlpf_checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [ELEM_W-1:0] got,
                               input logic [ELEM_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // earliest element of the lowest populated level, -1 when nothing stored
    function automatic int front_slot();
        int pick = -1;
        for (int i = 0; i < stored_q.size(); i++)
            if (pick < 0 || stored_q[i].lvl < stored_q[pick].lvl)
                pick = i;
        return pick;
    endfunction

    function automatic queue_view_t apply_op(input logic [MODE_W-1:0] m,
                                             input logic [ELEM_W-1:0] e,
                                             input logic [LEVEL_W-1:0] l);
        queue_view_t   v;
        stored_entry_t s;
        int            f;
        v = '0;
        v.status = STATUS_OK;
        if (m == MODE_ENQ)
        begin
            if (l > highest_allowed)
                v.status = STATUS_BAD_LEVEL;
            else if (stored_q.size() >= CAPACITY_DEF)
                v.status = STATUS_FULL;
            else
            begin
                s.lvl   = l;
                s.value = e;
                stored_q.push_back(s);
            end
        end
        else if (m == MODE_DEQ)
        begin
            f = front_slot();
            if (f < 0)
                v.status = STATUS_EMPTY;
            else
            begin
                v.removed = stored_q[f].value;
                stored_q.delete(f);
            end
        end
        // any other mode only reports
        f = front_slot();
        if (f >= 0)
        begin
            v.head     = stored_q[f].value;
            v.head_lvl = stored_q[f].lvl;
        end
        v.cnt   = COUNT_W'(stored_q.size());
        v.empty = (stored_q.size() == 0);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_view_t want;
        if (!rst_n)
        begin
            stored_q.delete();
            expected_q.delete();
            highest_allowed = HIGHEST_LEVEL_RESET;
        end
        else
        begin
            // a result leaving now always belongs to an earlier item
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with no item waiting");
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", ELEM_W'(status), ELEM_W'(want.status));
                    check_field("removed_elem", removed_elem, want.removed);
                    check_field("head_elem", head_elem, want.head);
                    check_field("head_level", ELEM_W'(head_level), ELEM_W'(want.head_lvl));
                    check_field("count", ELEM_W'(count), ELEM_W'(want.cnt));
                    check_field("is_empty", ELEM_W'(is_empty), ELEM_W'(want.empty));
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(apply_op(mode, elem, level));
            if (cfg_wr_en)
                highest_allowed = cfg_wr_data;
        end
        pending = expected_q.size();
    end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the priority fifo with directed and random items under several
// sender and receiver idling mixes and settings of the highest level, and
// gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import mlpf_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LEVEL_W-1:0]  cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic [MODE_W-1:0]   mode        = MODE_QUERY;
    logic [ELEM_W-1:0]   elem        = '0;
    logic [LEVEL_W-1:0]  level       = '0;
    logic                out_stall   = 1'b0;

    logic                in_stall;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   removed_elem;
    logic [ELEM_W-1:0]   head_elem;
    logic [LEVEL_W-1:0]  head_level;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    int                  fail_count;
    int                  pending;

    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    logic [LEVEL_W-1:0]  highest   = HIGHEST_LEVEL_RESET;

    multi_level_priority_fifo_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .elem         (elem),
        .level        (level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .removed_elem (removed_elem),
        .head_elem    (head_elem),
        .head_level   (head_level),
        .count        (count),
        .is_empty     (is_empty)
    );

    mlpf_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // valid stays high from one item to the next unless a gap is drawn
    task automatic push_op(input logic [MODE_W-1:0] m, input logic [ELEM_W-1:0] e,
                           input logic [LEVEL_W-1:0] l);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        elem     <= e;
        level    <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic set_highest(input logic [LEVEL_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        highest = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_op();
        int                 pick;
        logic [MODE_W-1:0]  m;
        logic [ELEM_W-1:0]  e;
        logic [LEVEL_W-1:0] l;
        pick = $urandom_range(99);
        if (pick < 52)
            m = MODE_ENQ;
        else if (pick < 90)
            m = MODE_DEQ;
        else if (pick < 97)
            m = MODE_QUERY;
        else
            m = MODE_UNUSED;
        pick = $urandom_range(9);
        if (pick == 0)
            e = '0;
        else if (pick == 1)
            e = '1;
        else
            e = $urandom;
        // mostly legal levels, sometimes anything
        if ($urandom_range(4) == 0)
            l = LEVEL_W'($urandom_range(15));
        else
            l = LEVEL_W'($urandom_range(int'(highest)));
        push_op(m, e, l);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_highest(4'd15);
        push_op(MODE_QUERY, '0, '0);
        push_op(MODE_UNUSED, '1, 4'd15);
        push_op(MODE_DEQ, '0, '0);
        push_op(MODE_ENQ, 32'h0000_0000, 4'd15);
        push_op(MODE_ENQ, 32'hffff_ffff, 4'd0);
        push_op(MODE_ENQ, 32'h5a5a_a5a5, 4'd7);
        push_op(MODE_ENQ, 32'h1234_5678, 4'd0);
        push_op(MODE_QUERY, '1, 4'd3);
        repeat (4) push_op(MODE_DEQ, '1, '1);
        push_op(MODE_DEQ, '0, '0);

        // elements above a lowered highest level stay reachable
        push_op(MODE_ENQ, 32'hcafe_0009, 4'd9);
        set_highest(4'd0);
        push_op(MODE_ENQ, 32'h8765_4321, 4'd1);
        push_op(MODE_ENQ, 32'h8765_4321, 4'd15);
        push_op(MODE_ENQ, 32'h0000_0001, 4'd0);
        push_op(MODE_QUERY, '0, '0);
        push_op(MODE_DEQ, '0, '0);
        push_op(MODE_DEQ, '0, '0);
        push_op(MODE_DEQ, '0, '0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (p == 1)
                set_highest(4'd0);
            else if (p == 2)
                set_highest(LEVEL_W'($urandom_range(14, 1)));
            else
                set_highest(4'd15);

            if (p == 0)
            begin
                // fill the pool past capacity, then empty it past zero
                repeat (CAPACITY_DEF + 14)
                    push_op(MODE_ENQ, $urandom, LEVEL_W'($urandom_range(15)));
                repeat (CAPACITY_DEF + 16)
                    push_op(MODE_DEQ, $urandom, LEVEL_W'($urandom_range(15)));
            end
            repeat (90) random_op();
            if (p == 3)
                settle();
            repeat (85) random_op();
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
